[hw/rtl/lzwc_pkg.sv]
`default_nettype none
package lzwc_pkg;

   // Default sizing
   localparam int DICT_ENTRIES_DEF  = 4096;
   localparam int MAX_CODE_BITS_DEF = 12;
   localparam int RESET_LIMIT_DEF   = 4092;

   // Fixed codes of the stream
   localparam int CODE_RESET  = 256;
   localparam int CODE_END    = 257;
   localparam int CODE_FIRST  = 258;
   localparam int START_WIDTH = 9;

   // Code width field holds values up to 31
   localparam int WIDTH_W = 5;
   localparam int EPOCH_W = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic               fin;
   } code_ctrl_type;

endpackage
`default_nettype wire

[hw/rtl/lzwc_front.sv]
`default_nettype none
module lzwc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last_byte,
   output logic                   item_valid,
   output lzwc_pkg::item_type     item,
   input  wire logic              item_pop
);

   lzwc_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   // Two-word queue between the port and the engine
   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{data_byte: req_data_byte, last_byte: req_last_byte};
      end
   end

endmodule
`default_nettype wire

[hw/rtl/lzwc_engine.sv]
`default_nettype none
module lzwc_engine #(
   parameter int DICT_ENTRIES  = lzwc_pkg::DICT_ENTRIES_DEF,
   parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF,
   parameter int RESET_LIMIT   = lzwc_pkg::RESET_LIMIT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     item_valid,
   input  wire lzwc_pkg::item_type       item,
   output logic                          item_pop,
   output logic                          code_valid,
   output logic [MAX_CODE_BITS-1:0]      code,
   output lzwc_pkg::code_ctrl_type       code_ctrl,
   input  wire logic                     code_ready
);

   localparam int CODE_W     = MAX_CODE_BITS;
   localparam int HT_ENTRIES = 2 * DICT_ENTRIES;
   localparam int HB         = $clog2(HT_ENTRIES);
   localparam int EW         = lzwc_pkg::EPOCH_W;
   localparam int WW         = lzwc_pkg::WIDTH_W;
   localparam int ENT_W      = EW + CODE_W + 8 + CODE_W;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RST1  = 4'd2;
   localparam logic [3:0] S_MATCH = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_PFX   = 4'd6;
   localparam logic [3:0] S_RST2  = 4'd7;
   localparam logic [3:0] S_LAST  = 4'd8;
   localparam logic [3:0] S_PFX2  = 4'd9;
   localparam logic [3:0] S_END   = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [CODE_W-1:0] prefix_ff, prefix_in;
   logic              pvalid_ff, pvalid_in;
   logic              started_ff, started_in;
   logic [CODE_W-1:0] next_code_ff, next_code_in;
   logic [WW-1:0]     width_ff, width_in;
   logic [EW-1:0]     epoch_ff, epoch_in;
   logic [HB-1:0]     probe_addr_ff, probe_addr_in;
   logic [HB-1:0]     clr_addr_ff, clr_addr_in;
   logic              clr_to_idle_ff, clr_to_idle_in;

   logic [ENT_W-1:0]  dict_mem [HT_ENTRIES];
   logic [ENT_W-1:0]  rd_data_ff;
   logic              mem_we;
   logic [HB-1:0]     mem_waddr;
   logic [ENT_W-1:0]  mem_wdata;

   logic [EW-1:0]     ent_tag;
   logic [CODE_W-1:0] ent_prefix;
   logic [7:0]        ent_byte;
   logic [CODE_W-1:0] ent_code;
   logic              dict_full;
   logic [HB-1:0]     hash;
   logic [31:0]       nc_plus;

   // Split the entry read back
   assign ent_tag    = rd_data_ff[ENT_W-1 -: EW];
   assign ent_prefix = rd_data_ff[ENT_W-EW-1 -: CODE_W];
   assign ent_byte   = rd_data_ff[CODE_W+7 -: 8];
   assign ent_code   = rd_data_ff[CODE_W-1:0];

   assign hash    = HB'(prefix_ff) ^ (HB'(byte_ff) << (HB - 8));
   assign nc_plus = 32'(next_code_ff) + 32'd1;
   assign dict_full = (32'(next_code_ff) > 32'(RESET_LIMIT))
                   || (32'(next_code_ff) >= 32'(DICT_ENTRIES))
                   || (nc_plus >= (32'd1 << MAX_CODE_BITS));

   // Codes towards the packer
   always_comb begin
      code_valid     = 1'b0;
      code           = prefix_ff;
      code_ctrl.width = width_ff;
      code_ctrl.fin  = 1'b0;
      case (state_ff)
         S_RST1, S_RST2: begin
            code_valid = 1'b1;
            code       = CODE_W'(lzwc_pkg::CODE_RESET);
         end
         S_PFX, S_PFX2: begin
            code_valid = 1'b1;
         end
         S_END: begin
            code_valid    = 1'b1;
            code          = CODE_W'(lzwc_pkg::CODE_END);
            code_ctrl.fin = 1'b1;
         end
         default: begin
            code_valid = 1'b0;
         end
      endcase
   end

   // Per byte: probe, insert, emit; also resets and clearing
   always_comb begin
      state_in       = state_ff;
      byte_in        = byte_ff;
      last_in        = last_ff;
      prefix_in      = prefix_ff;
      pvalid_in      = pvalid_ff;
      started_in     = started_ff;
      next_code_in   = next_code_ff;
      width_in       = width_ff;
      epoch_in       = epoch_ff;
      probe_addr_in  = probe_addr_ff;
      clr_addr_in    = clr_addr_ff;
      clr_to_idle_in = clr_to_idle_ff;
      item_pop       = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = probe_addr_ff;
      mem_wdata      = {epoch_ff, prefix_ff, byte_ff, next_code_ff};

      case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + HB'(1);
            if (clr_addr_ff == {HB{1'b1}}) begin
               state_in = clr_to_idle_ff ? S_IDLE : S_LAST;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               byte_in  = item.data_byte;
               last_in  = item.last_byte;
               state_in = started_ff ? S_MATCH : S_RST1;
            end
         end
         S_RST1: begin
            if (code_ready) begin
               started_in = 1'b1;
               state_in   = S_MATCH;
            end
         end
         S_MATCH: begin
            if (!pvalid_ff) begin
               prefix_in = CODE_W'(byte_ff);
               pvalid_in = 1'b1;
               state_in  = S_LAST;
            end else begin
               probe_addr_in = hash;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (ent_tag != epoch_ff) begin
               state_in = S_PFX;
            end else if (ent_prefix == prefix_ff && ent_byte == byte_ff) begin
               prefix_in = ent_code;
               state_in  = S_LAST;
            end else begin
               probe_addr_in = probe_addr_ff + HB'(1);
               state_in      = S_READ;
            end
         end
         S_PFX: begin
            if (code_ready) begin
               if (dict_full) begin
                  state_in = S_RST2;
               end else begin
                  mem_we       = 1'b1;
                  next_code_in = CODE_W'(nc_plus);
                  if (nc_plus >= (32'd1 << width_ff)
                      && 32'(width_ff) < MAX_CODE_BITS) begin
                     width_in = width_ff + WW'(1);
                  end
                  prefix_in = CODE_W'(byte_ff);
                  state_in  = S_LAST;
               end
            end
         end
         S_RST2: begin
            if (code_ready) begin
               next_code_in   = CODE_W'(lzwc_pkg::CODE_FIRST);
               width_in       = WW'(lzwc_pkg::START_WIDTH);
               prefix_in      = CODE_W'(byte_ff);
               clr_to_idle_in = 1'b0;
               if (epoch_ff == {EW{1'b1}}) begin
                  epoch_in    = EW'(1);
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + EW'(1);
                  state_in = S_LAST;
               end
            end
         end
         S_LAST: begin
            state_in = last_ff ? S_PFX2 : S_IDLE;
         end
         S_PFX2: begin
            if (code_ready) begin
               state_in = S_END;
            end
         end
         S_END: begin
            if (code_ready) begin
               next_code_in   = CODE_W'(lzwc_pkg::CODE_FIRST);
               width_in       = WW'(lzwc_pkg::START_WIDTH);
               pvalid_in      = 1'b0;
               started_in     = 1'b0;
               clr_to_idle_in = 1'b1;
               if (epoch_ff == {EW{1'b1}}) begin
                  epoch_in    = EW'(1);
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + EW'(1);
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         pvalid_ff      <= 1'b0;
         started_ff     <= 1'b0;
         next_code_ff   <= CODE_W'(lzwc_pkg::CODE_FIRST);
         width_ff       <= WW'(lzwc_pkg::START_WIDTH);
         epoch_ff       <= EW'(1);
         clr_addr_ff    <= '0;
         clr_to_idle_ff <= 1'b1;
      end else begin
         state_ff       <= state_in;
         pvalid_ff      <= pvalid_in;
         started_ff     <= started_in;
         next_code_ff   <= next_code_in;
         width_ff       <= width_in;
         epoch_ff       <= epoch_in;
         clr_addr_ff    <= clr_addr_in;
         clr_to_idle_ff <= clr_to_idle_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      prefix_ff     <= prefix_in;
      probe_addr_ff <= probe_addr_in;
   end

   // Hash table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dict_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= dict_mem[probe_addr_ff];
   end

endmodule
`default_nettype wire

[hw/rtl/lzwc_pack.sv]
`default_nettype none
module lzwc_pack #(
   parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     code_valid,
   input  wire logic [MAX_CODE_BITS-1:0] code,
   input  wire lzwc_pkg::code_ctrl_type  code_ctrl,
   output logic                          code_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_stream_end
);

   localparam int CODE_W = MAX_CODE_BITS;
   localparam int BUF_W  = CODE_W + 8;
   localparam int CNT_W  = $clog2(BUF_W + 1);

   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fin_ff, fin_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             end_ff, end_in;
   logic             out_free;
   logic [BUF_W-1:0] shifted;
   logic [BUF_W-1:0] padded;
   logic [CODE_W-1:0] masked;
   logic [CNT_W-1:0] cnt_less;

   assign out_free   = !valid_ff || !rsp_stall;
   assign code_ready = !fin_ff && (cnt_ff < CNT_W'(8));
   assign masked     = code & ~({CODE_W{1'b1}} << code_ctrl.width);
   assign cnt_less   = cnt_ff - CNT_W'(8);
   assign shifted    = buf_ff >> cnt_less;
   assign padded     = buf_ff << (CNT_W'(8) - cnt_ff);

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_stream_end = end_ff;

   // Drain full bytes, flush the tail, else take the next code
   always_comb begin
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      valid_in = valid_ff && rsp_stall;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (cnt_ff >= CNT_W'(8)) begin
         if (out_free) begin
            valid_in = 1'b1;
            byte_in  = shifted[7:0];
            end_in   = fin_ff && (cnt_less == '0);
            cnt_in   = cnt_less;
            if (cnt_less == '0) begin
               fin_in = 1'b0;
            end
         end
      end else if (fin_ff) begin
         if (cnt_ff == '0) begin
            fin_in = 1'b0;
         end else if (out_free) begin
            valid_in = 1'b1;
            byte_in  = padded[7:0];
            end_in   = 1'b1;
            cnt_in   = '0;
            fin_in   = 1'b0;
         end
      end else if (code_valid) begin
         buf_in = (buf_ff << code_ctrl.width) | BUF_W'(masked);
         cnt_in = cnt_ff + CNT_W'(code_ctrl.width);
         fin_in = code_ctrl.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

endmodule
`default_nettype wire

[hw/rtl/lzw_variable_width_compressor.sv]
`default_nettype none
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    data_byte[7:0], last_byte
// rsp      out        rsp_valid/stall    out_byte[7:0], stream_end
//
// Per byte, a probe reads the hash table and checks the entry, reprobing on
// a collision; a miss emits the prefix code and inserts the entry. A stream's
// first byte needs no probe; a reset code and the last byte's prefix and end
// codes are extra emissions. Each code waits until the packer holds fewer
// than 8 bits. After reset and every fifteenth dictionary reset or stream
// end, a pass clears all 2*DICT_ENTRIES entries before the next byte. Inputs
// queue two words deep; output bytes sit in one register.
module lzw_variable_width_compressor #(
   parameter int DICT_ENTRIES  = lzwc_pkg::DICT_ENTRIES_DEF,
   parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF,
   parameter int RESET_LIMIT   = lzwc_pkg::RESET_LIMIT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_stream_end
);

   logic                          item_valid;
   lzwc_pkg::item_type            item;
   logic                          item_pop;
   logic                          code_valid;
   logic [MAX_CODE_BITS-1:0]      code;
   lzwc_pkg::code_ctrl_type       code_ctrl;
   logic                          code_ready;

   lzwc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   lzwc_engine #(
      .DICT_ENTRIES  (DICT_ENTRIES),
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .RESET_LIMIT   (RESET_LIMIT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .code_valid (code_valid),
      .code       (code),
      .code_ctrl  (code_ctrl),
      .code_ready (code_ready)
   );

   lzwc_pack #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_pack (
      .clock          (clock),
      .reset          (reset),
      .code_valid     (code_valid),
      .code           (code),
      .code_ctrl      (code_ctrl),
      .code_ready     (code_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule
`default_nettype wire
